// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the design folder.
// The using module provides clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/pfd_pkg.sv
// ----------------------------------------------------------------------------
// pfd_pkg
// Constants, status codes and helper functions of the printout frame detector.
// ----------------------------------------------------------------------------
package pfd_pkg;

	// run buffer size and derived counter width
	localparam int BUFFER_BYTES = 512;
	localparam int CNT_W        = $clog2(BUFFER_BYTES);

	// output field widths
	localparam int STATUS_W = 3;
	localparam int START_W  = 9;
	localparam int FIXES_W  = 3;

	// frame geometry
	localparam int PAYLOAD_LEN = 54;
	localparam int MIN_STARS   = 7;
	localparam int MIN_TEXT    = 53;
	localparam int FIX_AT_TEXT = 55;
	localparam int MARK_FROM   = 30;
	localparam int NUM_FIXES   = 7;

	// text length saturates above every threshold that is tested
	localparam int TL_W   = 6;
	localparam int TL_MAX = (1 << TL_W) - 1;

	// star tally saturates above the star threshold
	localparam int TALLY_W   = 4;
	localparam int TALLY_MAX = (1 << TALLY_W) - 1;

	// characters
	localparam logic [7:0] STAR     = 8'h2A;
	localparam logic [7:0] LETTER_D = 8'h44;
	localparam logic [7:0] DIGIT_0  = 8'h30;
	localparam logic [7:0] DIGIT_9  = 8'h39;
	localparam logic [7:0] MARK_ONE = 8'h01;

	// status codes
	localparam logic [STATUS_W-1:0] ST_NEED     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_COMPLETE = 3'd1;
	localparam logic [STATUS_W-1:0] ST_RESET    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_ABORT    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
	localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd5;

	// rule for the byte right of a fix offset
	localparam logic [1:0] RIGHT_DIGIT = 2'd0;
	localparam logic [1:0] RIGHT_D     = 2'd1;
	localparam logic [1:0] RIGHT_ANY   = 2'd2;

	typedef logic [5:0] fix_pos_t;
	typedef logic [1:0] fix_rule_t;

	localparam fix_pos_t FIX_POS [NUM_FIXES] = '{
		6'd11, 6'd17, 6'd24, 6'd29, 6'd33, 6'd47, 6'd53
	};
	localparam fix_rule_t FIX_RIGHT [NUM_FIXES] = '{
		RIGHT_DIGIT, RIGHT_D, RIGHT_DIGIT, RIGHT_DIGIT,
		RIGHT_DIGIT, RIGHT_DIGIT, RIGHT_ANY
	};

	// decimal digit test
	function automatic logic is_digit(input logic [7:0] b);
		return (b >= DIGIT_0) && (b <= DIGIT_9);
	endfunction

	// number of set fix marks
	function automatic logic [FIXES_W-1:0] count_marks(input logic [NUM_FIXES-1:0] m);
		logic [FIXES_W-1:0] n;
		n = '0;
		for (int k = 0; k < NUM_FIXES; k++) begin
			n = n + FIXES_W'(m[k]);
		end
		return n;
	endfunction

	// saturating add to the star tally
	function automatic logic [TALLY_W-1:0] tally_add(input logic [TALLY_W-1:0] t,
			input logic [FIXES_W-1:0] a);
		logic [TALLY_W:0] s;
		s = {1'b0, t} + (TALLY_W+1)'(a);
		if (s > (TALLY_W+1)'(TALLY_MAX)) begin
			return TALLY_W'(TALLY_MAX);
		end
		return s[TALLY_W-1:0];
	endfunction

endpackage

// File: design/printout_frame_detector_top.sv
// ----------------------------------------------------------------------------
// printout_frame_detector_top
// Tracks a star-delimited printout payload in a received modem byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one received byte per request
//   in rx_byte; new_call set on a request clears all tracking before that
//   byte is taken. Output channel (out_valid / out_stall) returns one result
//   per input request: status, payload_start and fixes_applied.
//   A request taken into the input stage register shows its result once the
//   result register takes it. Throughput: one request per cycle while out_stall
//   is low; the whole per-byte update sits between the two registers.
//   When the receiver stalls, the result register holds and the input stage
//   keeps at most one more request; in_stall rises once that stage is full.
//   After a completion, an abort or a full buffer every byte returns status
//   ignored and changes nothing until a request with new_call set.
//   Reset empties both registers and clears all tracking state.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module printout_frame_detector_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    rx_byte,
	input  logic                          new_call,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [pfd_pkg::STATUS_W-1:0]  status,
	output logic [pfd_pkg::START_W-1:0]   payload_start,
	output logic [pfd_pkg::FIXES_W-1:0]   fixes_applied
);

	localparam int CW = pfd_pkg::CNT_W;
	localparam int TW = pfd_pkg::TL_W;
	localparam int AW = pfd_pkg::TALLY_W;
	localparam int NF = pfd_pkg::NUM_FIXES;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       new_call_s1;

	// result register
	logic                         out_valid_q;
	logic [pfd_pkg::STATUS_W-1:0] status_q;
	logic [pfd_pkg::START_W-1:0]  start_q;
	logic [pfd_pkg::FIXES_W-1:0]  fixes_q;

	// tracking state
	logic [CW-1:0] run_q;
	logic          seen_q;
	logic [CW-1:0] start_idx_q;
	logic          open_q;
	logic [TW-1:0] text_len_q;
	logic [AW-1:0] tally_q;
	logic [NF-1:0] marks_q;
	logic          done_q;
	logic [15:0]   last2_q;
	logic          marker_q;
	logic [1:0]    corrupt_q;
	logic          ended_q;

	// state as seen by the byte in the input stage
	logic [CW-1:0] e_run, e_start;
	logic          e_seen, e_open, e_done, e_marker, e_ended;
	logic [TW-1:0] e_tl;
	logic [AW-1:0] e_tally;
	logic [NF-1:0] e_marks;
	logic [15:0]   e_last2;
	logic [1:0]    e_corrupt;

	// next state
	logic [CW-1:0] n_run, n_start;
	logic          n_seen, n_open, n_done, n_marker, n_ended;
	logic [TW-1:0] n_tl;
	logic [AW-1:0] n_tally;
	logic [NF-1:0] n_marks;
	logic [15:0]   n_last2;
	logic [1:0]    n_corrupt;

	// step results
	logic [pfd_pkg::STATUS_W-1:0] res_status;
	logic [CW-1:0]                res_start;
	logic [pfd_pkg::FIXES_W-1:0]  res_fixes;
	logic [7:0]                   prev1, prev2;
	logic [CW-1:0]                run_inc;
	logic                         right_ok, complete;

	// handshake
	logic advance, proc;

	assign advance  = !out_valid_q || !out_stall;
	assign proc     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign payload_start = start_q;
	assign fixes_applied = fixes_q;

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1     <= rx_byte;
			new_call_s1 <= new_call;
		end
	end

	// apply a new call clear ahead of the byte
	always_comb begin
		if (new_call_s1) begin
			e_run     = '0;
			e_seen    = 1'b0;
			e_start   = '0;
			e_open    = 1'b1;
			e_tl      = '0;
			e_tally   = '0;
			e_marks   = '0;
			e_done    = 1'b0;
			e_last2   = '0;
			e_marker  = 1'b0;
			e_corrupt = '0;
			e_ended   = 1'b0;
		end else begin
			e_run     = run_q;
			e_seen    = seen_q;
			e_start   = start_idx_q;
			e_open    = open_q;
			e_tl      = text_len_q;
			e_tally   = tally_q;
			e_marks   = marks_q;
			e_done    = done_q;
			e_last2   = last2_q;
			e_marker  = marker_q;
			e_corrupt = corrupt_q;
			e_ended   = ended_q;
		end
	end

	// per-byte update
	always_comb begin
		n_run      = e_run;
		n_seen     = e_seen;
		n_start    = e_start;
		n_open     = e_open;
		n_tl       = e_tl;
		n_tally    = e_tally;
		n_marks    = e_marks;
		n_done     = e_done;
		n_last2    = e_last2;
		n_marker   = e_marker;
		n_corrupt  = e_corrupt;
		n_ended    = e_ended;
		prev1      = e_last2[7:0];
		prev2      = e_last2[15:8];
		run_inc    = e_run + 1'b1;
		right_ok   = 1'b0;
		complete   = 1'b0;
		res_status = pfd_pkg::ST_NEED;
		res_start  = e_start;
		res_fixes  = e_done ? pfd_pkg::count_marks(e_marks) : '0;

		if (e_ended) begin
			res_status = pfd_pkg::ST_IGNORED;
		end else begin
			n_run = run_inc;

			// first star opens the payload
			if (!e_seen && byte_s1 == pfd_pkg::STAR) begin
				n_seen  = 1'b1;
				n_start = e_run;
			end

			// text tracking up to the first zero byte
			if (n_seen && e_open) begin
				if (byte_s1 == 8'h00) begin
					n_open = 1'b0;
				end else begin
					for (int k = 0; k < NF; k++) begin
						case (pfd_pkg::FIX_RIGHT[k])
							pfd_pkg::RIGHT_DIGIT: right_ok = pfd_pkg::is_digit(byte_s1);
							pfd_pkg::RIGHT_D:     right_ok = (byte_s1 == pfd_pkg::LETTER_D);
							default:              right_ok = 1'b1;
						endcase
						if (e_tl == TW'(pfd_pkg::FIX_POS[k] + 6'd1) && right_ok &&
								prev1 != pfd_pkg::STAR && pfd_pkg::is_digit(prev2)) begin
							n_marks[k] = 1'b1;
						end
					end
					if (byte_s1 == pfd_pkg::STAR) begin
						n_tally = pfd_pkg::tally_add(e_tally, pfd_pkg::FIXES_W'(1));
					end
					if (e_tl != TW'(pfd_pkg::TL_MAX)) begin
						n_tl = e_tl + 1'b1;
					end
				end
			end

			// corruption marker after the payload area
			if (e_run >= CW'(pfd_pkg::MARK_FROM + 2) && prev1 == 8'h00 &&
					byte_s1 == 8'h00 && (prev2 == 8'h00 || prev2 == pfd_pkg::MARK_ONE)) begin
				n_marker = 1'b1;
			end

			n_last2 = {prev1, byte_s1};

			// fixes are counted once the text is long enough
			if (!e_done && n_tl >= TW'(pfd_pkg::FIX_AT_TEXT)) begin
				n_done  = 1'b1;
				n_tally = pfd_pkg::tally_add(n_tally, pfd_pkg::count_marks(n_marks));
			end

			res_start = n_start;
			res_fixes = n_done ? pfd_pkg::count_marks(n_marks) : '0;

			complete = (run_inc >= CW'(pfd_pkg::PAYLOAD_LEN)) && n_seen &&
				((run_inc - n_start) >= CW'(pfd_pkg::PAYLOAD_LEN)) &&
				(n_tally >= AW'(pfd_pkg::MIN_STARS)) &&
				(n_tl >= TW'(pfd_pkg::MIN_TEXT));

			// final decision for this byte
			if (complete) begin
				res_status = pfd_pkg::ST_COMPLETE;
				n_ended    = 1'b1;
			end else if (run_inc > CW'(pfd_pkg::PAYLOAD_LEN) && n_marker) begin
				n_corrupt = e_corrupt + 1'b1;
				if (e_corrupt != 2'd0) begin
					res_status = pfd_pkg::ST_ABORT;
					n_ended    = 1'b1;
				end else begin
					res_status = pfd_pkg::ST_RESET;
					n_run      = '0;
					n_seen     = 1'b0;
					n_start    = '0;
					n_open     = 1'b1;
					n_tl       = '0;
					n_tally    = '0;
					n_marks    = '0;
					n_done     = 1'b0;
					n_last2    = '0;
					n_marker   = 1'b0;
				end
			end else if (run_inc >= CW'(pfd_pkg::BUFFER_BYTES - 1)) begin
				res_status = pfd_pkg::ST_FULL;
				n_ended    = 1'b1;
			end
		end
	end

	// tracking state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q       <= '0;
			seen_q      <= 1'b0;
			start_idx_q <= '0;
			open_q      <= 1'b1;
			text_len_q  <= '0;
			tally_q     <= '0;
			marks_q     <= '0;
			done_q      <= 1'b0;
			last2_q     <= '0;
			marker_q    <= 1'b0;
			corrupt_q   <= '0;
			ended_q     <= 1'b0;
		end else if (proc) begin
			run_q       <= n_run;
			seen_q      <= n_seen;
			start_idx_q <= n_start;
			open_q      <= n_open;
			text_len_q  <= n_tl;
			tally_q     <= n_tally;
			marks_q     <= n_marks;
			done_q      <= n_done;
			last2_q     <= n_last2;
			marker_q    <= n_marker;
			corrupt_q   <= n_corrupt;
			ended_q     <= n_ended;
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (proc) begin
			status_q <= res_status;
			start_q  <= pfd_pkg::START_W'(res_start);
			fixes_q  <= res_fixes;
		end
	end

	// checks
	`ASSERT_ALWAYS(a_run_bound, run_q <= CW'(pfd_pkg::BUFFER_BYTES - 1), "run count past buffer")
	`ASSERT_ALWAYS(a_corrupt_bound, corrupt_q <= 2'd2, "corrupt reset count out of range")
	`ASSERT_ALWAYS(a_ended_shown, !(out_valid_q && (status_q == pfd_pkg::ST_COMPLETE || status_q == pfd_pkg::ST_ABORT || status_q == pfd_pkg::ST_FULL)) || ended_q, "call end not recorded")
	`ASSERT_NEXT(a_ignored_after_end, proc && ended_q && !new_call_s1, status_q == pfd_pkg::ST_IGNORED, "byte after end not ignored")

endmodule
